// ----- rtl/core/subpicture_rle_decoder_core_macros.svh -----
// Assertion macros shared by the subpicture run-length decoder RTL.
`ifndef SUBPICTURE_RLE_DECODER_CORE_MACROS_SVH
`define SUBPICTURE_RLE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/srle_pkg.sv -----
// Types and constants for the subpicture run-length decoder.
package srle_pkg;

	localparam logic [12:0] LINE_WIDTH_RESET  = 13'd720;
	localparam logic [11:0] FIELD_LINES_RESET = 12'd240;

	// Configuration register indexes
	localparam logic REG_LINE_WIDTH  = 1'b0;
	localparam logic REG_FIELD_LINES = 1'b1;

	// Smallest code value that closes a code of one, two or three nibbles
	localparam logic [15:0] CODE_MIN_1 = 16'h0004;
	localparam logic [15:0] CODE_MIN_2 = 16'h0010;
	localparam logic [15:0] CODE_MIN_3 = 16'h0040;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [15:0] acc;
		logic [2:0]  ncount;
		logic [12:0] column;
		logic [11:0] line;
		logic        field_done;
	} state_t;

	typedef struct packed {
		logic [1:0]  run_color;
		logic [12:0] run_length;
		logic [11:0] start_column;
		logic [10:0] line_number;
		logic        line_finished;
		logic        field_finished;
		logic        truncated;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] result_set_t;

endpackage

// ----- rtl/core/srle_in_reg.sv -----
// Input register: holds one data word until the decoder takes it.
module srle_in_reg
	import srle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       end_of_data,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       first_s1,
	output logic       eod_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
			eod_s1   <= end_of_data;
		end
	end

endmodule

// ----- rtl/core/srle_decode.sv -----
// Decoder: decodes the high nibble and, unless it ends a line, the low nibble of a word.
module srle_decode
	import srle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  byte_s1,
	input  logic        first_s1,
	input  logic        eod_s1,
	input  logic [12:0] width,
	input  logic [11:0] lines,
	output result_set_t res,
	output logic [1:0]  res_count
);

	typedef struct packed {
		state_t  st;
		logic    emit;
		logic    stop;
		result_t res;
	} step_t;

	function automatic step_t nib_step(state_t st, logic [3:0] nib, logic [12:0] w,
			logic [11:0] h);
		step_t       r;
		logic [15:0] v;
		logic [2:0]  n1;
		logic        done;
		logic [12:0] rem;
		logic [12:0] len;
		logic [12:0] ncol;
		logic [13:0] code_len;
		logic        fin;
		r = '0;
		r.st = st;
		v = {st.acc[11:0], nib};
		n1 = st.ncount + 3'd1;
		case (n1)
			3'd1:    done = (v >= CODE_MIN_1);
			3'd2:    done = (v >= CODE_MIN_2);
			3'd3:    done = (v >= CODE_MIN_3);
			default: done = 1'b1;
		endcase
		r.st.acc = v;
		r.st.ncount = n1;
		rem = (st.column < w) ? (w - st.column) : 13'd0;
		code_len = v[15:2];
		// zero length fills the line; anything longer is clipped at the line end
		len = (code_len == 14'd0 || code_len > {1'b0, rem}) ? rem : code_len[12:0];
		ncol = st.column + len;
		fin = ({1'b0, st.line} + 13'd1) >= {1'b0, h};
		if (done) begin
			r.st.acc = '0;
			r.st.ncount = '0;
			r.emit = 1'b1;
			r.res.run_color = v[1:0];
			r.res.run_length = len;
			r.res.start_column = st.column[11:0];
			r.res.line_number = st.line[10:0];
			if (ncol >= w) begin
				r.res.line_finished = 1'b1;
				r.res.field_finished = fin;
				r.stop = 1'b1;
				if (fin) begin
					r.st.column = ncol;
					r.st.field_done = 1'b1;
				end else begin
					r.st.line = st.line + 12'd1;
					r.st.column = '0;
				end
			end else begin
				r.st.column = ncol;
			end
		end
		return r;
	endfunction

	state_t state_q;
	state_t cur;
	state_t nxt;
	step_t  hi_step;
	step_t  lo_step;
	logic [1:0] n;

	always_comb begin
		cur = first_s1 ? '0 : state_q;
		nxt = cur;
		res = '0;
		n = 2'd0;
		hi_step = nib_step(cur, byte_s1[7:4], width, lines);
		lo_step = nib_step(hi_step.st, byte_s1[3:0], width, lines);
		if (!cur.field_done) begin
			nxt = hi_step.st;
			if (hi_step.emit) begin
				res[n] = hi_step.res;
				n = n + 2'd1;
			end
			// a line end skips the low nibble to realign on a word
			if (!hi_step.stop) begin
				nxt = lo_step.st;
				if (lo_step.emit) begin
					res[n] = lo_step.res;
					n = n + 2'd1;
				end
			end
			if (eod_s1 && !nxt.field_done) begin
				res[n].start_column = nxt.column[11:0];
				res[n].line_number = nxt.line[10:0];
				res[n].truncated = 1'b1;
				n = n + 2'd1;
				nxt.acc = '0;
				nxt.ncount = '0;
				nxt.field_done = 1'b1;
			end
		end
		res_count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			state_q <= nxt;
		end
	end

endmodule

// ----- rtl/core/srle_out_queue.sv -----
// Result register: holds the results of one word and hands them out in order.
module srle_out_queue
	import srle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_set_t res,
	input  logic [1:0]  res_count,
	output logic        free,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     head,
	output logic        last
);

	result_set_t res_s2;
	logic [1:0]  cnt_s2;

	assign out_valid = (cnt_s2 != 2'd0);
	assign free      = (cnt_s2 == 2'd0) || (cnt_s2 == 2'd1 && out_ready);
	assign head      = res_s2[0];
	assign last      = (cnt_s2 == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
		end else if (load) begin
			cnt_s2 <= res_count;
		end else if (out_valid && out_ready) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end else if (out_valid && out_ready) begin
			// advance the next result to the head
			res_s2[0] <= res_s2[1];
			res_s2[1] <= res_s2[2];
		end
	end

endmodule

// ----- rtl/core/subpicture_rle_decoder_core.sv -----
// Subpicture run-length decoder core: one field of a 2-bit bitmap, one word per cycle.
// A word is held in the input register, then decoded combinationally and its results
// loaded into the result register, from which they are offered in order.
// Throughput: one word per cycle while each word gives at most one result and
// out_ready is high; a word with more results holds the result register until
// its last result is accepted. Reset clears the stream position and empties both
// stages; registers return to 720 pixels per line and 240 lines.
module subpicture_rle_decoder_core
	import srle_pkg::*;
#(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_LINES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        end_of_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  run_color,
	output logic [12:0] run_length,
	output logic [11:0] start_column,
	output logic [10:0] line_number,
	output logic        line_finished,
	output logic        field_finished,
	output logic        truncated,
	output logic        last_of_item
);

`include "subpicture_rle_decoder_core_macros.svh"

	logic [12:0] line_width_q;
	logic [11:0] field_lines_q;
	logic [12:0] width;
	logic [11:0] lines;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        eod_s1;
	logic        take;
	logic        free;
	result_set_t res;
	logic [1:0]  res_count;
	result_t     head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q  <= LINE_WIDTH_RESET;
			field_lines_q <= FIELD_LINES_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LINE_WIDTH:  line_width_q  <= cfg_data;
				REG_FIELD_LINES: field_lines_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// clamp to 1..MAX
	assign width = (line_width_q == 13'd0) ? 13'd1 :
		(line_width_q > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : line_width_q;
	assign lines = (field_lines_q == 12'd0) ? 12'd1 :
		(field_lines_q > 12'(MAX_LINES)) ? 12'(MAX_LINES) : field_lines_q;

	assign take = valid_s1 && free;

	srle_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.end_of_data (end_of_data),
		.take        (take),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.first_s1    (first_s1),
		.eod_s1      (eod_s1)
	);

	srle_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_s1   (byte_s1),
		.first_s1  (first_s1),
		.eod_s1    (eod_s1),
		.width     (width),
		.lines     (lines),
		.res       (res),
		.res_count (res_count)
	);

	srle_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res       (res),
		.res_count (res_count),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.last      (last_of_item)
	);

	assign run_color      = head.run_color;
	assign run_length     = head.run_length;
	assign start_column   = head.start_column;
	assign line_number    = head.line_number;
	assign line_finished  = head.line_finished;
	assign field_finished = head.field_finished;
	assign truncated      = head.truncated;

	`SRLE_ASSERT_NOW(a_field_ends_line, clk, arst_n, out_valid && field_finished,
		line_finished, "field finished without line finished")
	`SRLE_ASSERT_NOW(a_field_end_last, clk, arst_n, out_valid && field_finished,
		last_of_item, "result after field end")
	`SRLE_ASSERT_NOW(a_trunc_shape, clk, arst_n, out_valid && truncated,
		run_length == 13'd0 && last_of_item && !line_finished, "bad truncation result")
	`SRLE_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, valid_s1 && !free,
		valid_s1, "pending word lost while result register busy")

endmodule
